// File: sv/nnu_pkg.sv
package nnu_pkg;

  // Input item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes.
  localparam int  CFG_INDEX_W = 1;
  localparam int  CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 1'b1;

  localparam int SCALE_W = 5;
  localparam int WIDTH_W = 11;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    pixel_t pix;
    logic   ends_row;
    logic   refused;
  } cmd_t;

endpackage

// File: sv/nnu_if.sv
interface nnu_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output kind, output blue, output green, output red,
                  input ready);
  modport sink (input valid, input kind, input blue, input green, input red,
                output ready);
endinterface

interface nnu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [1:0] pad_after;
  logic       row_end;
  logic       refused;
  logic       last;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output pad_after, output row_end, output refused, output last,
                  input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                input pad_after, input row_end, input refused, input last,
                output ready);
endinterface

interface nnu_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/nearest_neighbor_upscaler.sv
// Integer nearest-neighbor upscaler for rows of 24-bit pixels. Each source pixel
// item (kind 0) is written to a line store and comes out scale_factor times in a
// row; the source row's last pixel arms scale_factor - 1 replays of the row. Each
// replay tick item (kind 1) reads one pixel back from the line store and again
// sends it out scale_factor times. The last copy of each input item has last set,
// and the last pixel of every output row has row_end set and carries in pad_after
// the zero bytes that round the row to a multiple of four bytes. A pixel item that
// arrives while replays are still owed is answered by a single refused item with
// zero pixel data; a tick with nothing to replay yields no result. Out-of-range
// register values are clamped: zero acts as one, values above MAX_SCALE or
// MAX_WIDTH act as those limits. Rate: an item that yields results goes out as
// scale_factor copies (one for a refused pixel, 16 at the largest scale), set by
// the back-end copy counter, one result per cycle while the receiver is ready. The
// front end takes a new item every cycle while the two-entry queue between front
// and back has room, so consecutive items stream out without gaps; an item passes
// the front register, the queue and the back register before its first result. The
// line store has no clearing pass: it is read only at columns already written.
module nearest_neighbor_upscaler import nnu_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  nnu_in_if.sink    in_ch,
  nnu_out_if.source out_ch,
  nnu_cfg_if.sink   cfg_ch
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);

  // Raw register values, clamped below before use.
  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_r;
  logic [SW-1:0]      eff_scale;
  logic [WW-1:0]      eff_width;
  logic [1:0]         row_pad;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  // The configuration port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(1);
      width_r <= WIDTH_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SCALE: scale_r <= cfg_ch.data[SCALE_W-1:0];
        REG_WIDTH: width_r <= cfg_ch.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      eff_scale = SW'(1);
    end else if (32'(scale_r) > MAX_SCALE) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = SW'(scale_r);
    end
    if (width_r == '0) begin
      eff_width = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(width_r);
    end
  end

  // A row of width * scale pixels has 3 * width * scale bytes, so the padding to
  // the next multiple of four is (width * scale) mod 4; only the low two bits of
  // each factor matter.
  logic [1:0] w_lo, s_lo;
  assign w_lo    = 2'(32'(eff_width));
  assign s_lo    = 2'(32'(eff_scale));
  assign row_pad = 2'(w_lo * s_lo);

  nnu_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .eff_scale (eff_scale),
    .eff_width (eff_width),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  nnu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  nnu_back #(
    .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_scale(eff_scale),
    .row_pad  (row_pad),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );

  // A refused item is a single result that never ends a row.
  a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.refused) |-> (out_ch.last && !out_ch.row_end))
    else $error("refused item is not a lone last result");

  // A row can only end on the last copy of an item.
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.row_end) |-> out_ch.last)
    else $error("row end on a copy that is not the last");

  // Padding appears only at a row end.
  a_pad_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.pad_after != 2'd0) |-> out_ch.row_end)
    else $error("padding outside a row end");

  // After a result that is not last is taken, the next copy follows at once.
  a_copies_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("gap between copies of one item");

endmodule

// File: sv/nnu_ram.sv
module nnu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/nnu_queue.sv
module nnu_queue import nnu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : PW'(32'(wr_ptr_r) + 1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : PW'(32'(rd_ptr_r) + 1);
    end
    if (do_push && !do_pop) begin
      count_nxt = NW'(32'(count_r) + 1);
    end else if (do_pop && !do_push) begin
      count_nxt = NW'(32'(count_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/nnu_front.sv
module nnu_front import nnu_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int SW = $clog2(MAX_SCALE + 1),
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  nnu_in_if.sink        in_ch,
  input  logic [SW-1:0] eff_scale,
  input  logic [WW-1:0] eff_width,
  output logic          push_valid,
  input  logic          push_ready,
  output cmd_t          push_data
);

  logic [CW-1:0] wcol_r, wcol_nxt;
  logic [CW-1:0] rcol_r, rcol_nxt;
  logic [RW-1:0] rep_r, rep_nxt;
  logic          s1_v_r, s1_v_nxt;
  cmd_t          s1_cmd_r, s1_cmd_nxt;
  logic          s1_ram_r, s1_ram_nxt;

  logic   take, is_pix, pending, produces, wr_ends, rd_ends;
  logic   ram_wr, ram_rd;
  pixel_t in_pix;
  logic [23:0] rd_data;

  assign in_pix   = '{red: in_ch.red, green: in_ch.green, blue: in_ch.blue};
  assign in_ch.ready = !s1_v_r || push_ready;
  assign take     = in_ch.valid && in_ch.ready;
  assign is_pix   = (in_ch.kind == KIND_PIXEL);
  assign pending  = (rep_r != '0);
  assign produces = is_pix || pending;
  assign wr_ends  = (32'(wcol_r) + 1 >= 32'(eff_width));
  assign rd_ends  = (32'(rcol_r) + 1 >= 32'(eff_width));
  assign ram_wr   = take && is_pix && !pending;
  assign ram_rd   = take && !is_pix && pending;

  always_comb begin
    wcol_nxt   = wcol_r;
    rcol_nxt   = rcol_r;
    rep_nxt    = rep_r;
    s1_cmd_nxt = s1_cmd_r;
    s1_ram_nxt = s1_ram_r;
    if (take) begin
      s1_cmd_nxt = '0;
      s1_ram_nxt = 1'b0;
      if (is_pix && pending) begin
        s1_cmd_nxt.refused = 1'b1;
      end else if (is_pix) begin
        s1_cmd_nxt.pix      = in_pix;
        s1_cmd_nxt.ends_row = wr_ends;
        if (wr_ends) begin
          wcol_nxt = '0;
          rcol_nxt = '0;
          rep_nxt  = RW'(32'(eff_scale) - 1);
        end else begin
          wcol_nxt = CW'(32'(wcol_r) + 1);
        end
      end else if (pending) begin
        s1_cmd_nxt.ends_row = rd_ends;
        s1_ram_nxt          = 1'b1;
        if (rd_ends) begin
          rcol_nxt = '0;
          rep_nxt  = RW'(32'(rep_r) - 1);
        end else begin
          rcol_nxt = CW'(32'(rcol_r) + 1);
        end
      end
    end
  end

  always_comb begin
    if (take) begin
      s1_v_nxt = produces;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r <= '0;
      rcol_r <= '0;
      rep_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      wcol_r <= wcol_nxt;
      rcol_r <= rcol_nxt;
      rep_r  <= rep_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
    s1_ram_r <= s1_ram_nxt;
  end

  nnu_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(wcol_r),
    .wr_data(in_pix),
    .rd_en  (ram_rd),
    .rd_addr(rcol_r),
    .rd_data(rd_data)
  );

  // A replayed pixel picks up its value from the store's registered read.
  always_comb begin
    push_data = s1_cmd_r;
    if (s1_ram_r) begin
      push_data.pix = pixel_t'(rd_data);
    end
  end

  assign push_valid = s1_v_r;

endmodule

// File: sv/nnu_back.sv
module nnu_back import nnu_pkg::*; #(
  parameter int MAX_SCALE = 16,
  localparam int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] eff_scale,
  input  logic [1:0]    row_pad,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  cmd_t          pop_data,
  nnu_out_if.source     out_ch
);

  logic          busy_r, busy_nxt;
  cmd_t          cmd_r;
  logic [SW-1:0] copy_r, copy_nxt;
  logic          is_last, fire, do_pop;

  assign is_last   = cmd_r.refused || (32'(copy_r) + 1 == 32'(eff_scale));
  assign fire      = out_ch.valid && out_ch.ready;
  assign pop_ready = !busy_r || (fire && is_last);
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    busy_nxt = busy_r;
    copy_nxt = copy_r;
    if (do_pop) begin
      busy_nxt = 1'b1;
      copy_nxt = '0;
    end else if (fire && is_last) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      copy_nxt = SW'(32'(copy_r) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      copy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      copy_r <= copy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cmd_r <= pop_data;
    end
  end

  assign out_ch.valid     = busy_r;
  assign out_ch.out_blue  = cmd_r.pix.blue;
  assign out_ch.out_green = cmd_r.pix.green;
  assign out_ch.out_red   = cmd_r.pix.red;
  assign out_ch.row_end   = is_last && cmd_r.ends_row;
  assign out_ch.pad_after = (is_last && cmd_r.ends_row) ? row_pad : 2'd0;
  assign out_ch.refused   = cmd_r.refused;
  assign out_ch.last      = is_last;

endmodule

// File: verif/tb_nearest_neighbor_upscaler.sv
module tb_nearest_neighbor_upscaler import nnu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Random stimulus stops once this many items that produce results have been accepted.
  localparam int RANDOM_ITEMS = 120;
  // Cycles allowed for an item to clear the pipeline after the last result has
  // been taken. An item passes the front register, the two-entry queue and the
  // back register, so SETTLE_CYCLES is comfortably enough.
  localparam int SETTLE_CYCLES = 8;
  // The run fails if nothing moves on any channel for this many cycles. The
  // slowest correct stretch is the long receiver hold-off plus one random stall.
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_SCALE_CLAMP = 16;
  localparam int MAX_WIDTH_CLAMP = 1024;

  // One expected output pixel.
  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       row_end;
    logic       refused;
    logic       last_copy;
  } upscaled_px_t;

  logic clk;
  logic rst_n;

  nnu_in_if  in_ch();
  nnu_out_if out_ch();
  nnu_cfg_if cfg_ch();

  nearest_neighbor_upscaler i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the block's state and registers. It is advanced each time
  // an item is accepted and each time a register is written.
  pixel_t           line_buf [MAX_WIDTH_CLAMP];
  int unsigned      wr_col = 0;
  int unsigned      rp_col = 0;
  int unsigned      rows_owed = 0;
  logic [SCALE_W-1:0] scale_reg = 1;
  logic [WIDTH_W-1:0] width_reg = 1;

  // Expected output pixels, oldest first.
  upscaled_px_t pending_px[$];

  int  n_errors = 0;
  int  items_counted = 0;  // accepted items that produce at least one result
  bit  row_closed;         // set when a source pixel ends a row
  bit  in_offered = 0;     // input valid is currently driven high
  bit  tx_steady = 0;      // sender offers items back to back when set
  bit  rx_steady = 0;      // receiver never stalls when set
  int  hold_req = 0;       // long receiver hold-off requested by a test

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > MAX_SCALE_CLAMP) return MAX_SCALE_CLAMP;
    return scale_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_CLAMP) return MAX_WIDTH_CLAMP;
    return width_reg;
  endfunction

  // Queues the scaled copies of one pixel. Only the final copy can close an
  // output row, and only it carries the padding count.
  function automatic void queue_copies(pixel_t p, bit ends_row);
    int unsigned s;
    int unsigned pad;
    upscaled_px_t r;
    s   = eff_scale();
    pad = (4 - (3 * eff_width() * s) % 4) % 4;
    for (int unsigned k = 0; k < s; k++) begin
      r.blue      = p.blue;
      r.green     = p.green;
      r.red       = p.red;
      r.last_copy = (k + 1 == s);
      r.row_end   = r.last_copy && ends_row;
      r.pad       = r.row_end ? pad[1:0] : 2'd0;
      r.refused   = 1'b0;
      pending_px.push_back(r);
    end
  endfunction

  // Works out what one accepted item produces and advances the shadow state.
  function automatic void predict_upscale(logic kind, pixel_t p);
    bit ends_row;
    upscaled_px_t r;
    if (kind == KIND_PIXEL) begin
      items_counted++;
      if (rows_owed != 0) begin
        // A pixel that arrives while replays are owed is refused; the state is kept.
        r = '{blue: 8'd0, green: 8'd0, red: 8'd0, pad: 2'd0,
              row_end: 1'b0, refused: 1'b1, last_copy: 1'b1};
        pending_px.push_back(r);
        return;
      end
      line_buf[wr_col] = p;
      ends_row = (wr_col + 1 >= eff_width());
      if (ends_row) begin
        wr_col     = 0;
        rp_col     = 0;
        rows_owed  = eff_scale() - 1;
        row_closed = 1'b1;
      end else begin
        wr_col++;
      end
      queue_copies(p, ends_row);
    end else begin
      // A tick with nothing to replay is dropped without a result.
      if (rows_owed == 0) return;
      items_counted++;
      p = line_buf[rp_col];
      ends_row = (rp_col + 1 >= eff_width());
      if (ends_row) begin
        rp_col = 0;
        rows_owed--;
      end else begin
        rp_col++;
      end
      queue_copies(p, ends_row);
    end
  endfunction

  function automatic pixel_t any_pixel();
    return pixel_t'(24'($urandom()));
  endfunction

  task automatic drop_valid();
    if (in_offered) begin
      in_ch.valid <= 1'b0;
      in_offered = 1'b0;
    end
  endtask

  // Offers one item after a random gap and waits until the block takes it.
  // Valid stays high afterwards so that a following item can go back to back.
  task automatic send_item(logic kind, pixel_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.blue  <= p.blue;
    in_ch.green <= p.green;
    in_ch.red   <= p.red;
    in_offered = 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_upscale(kind, p);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, any_pixel());
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic wait_drain();
    drop_valid();
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  // Registers change only while the block is idle. Ticks that produce nothing
  // may still be in flight after the last result, hence the extra settle time.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == REG_SCALE) scale_reg = SCALE_W'(value);
    else width_reg = WIDTH_W'(value);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Receiver: stalls a random number of cycles before each result, honors a
  // long hold-off when a test asks for one, and checks every result it takes.
  initial begin
    int stall_left;
    upscaled_px_t want;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_px.size() == 0) begin
          $error("result with no item pending: blue %0d green %0d red %0d refused %0d",
                 out_ch.out_blue, out_ch.out_green, out_ch.out_red, out_ch.refused);
          n_errors++;
        end else begin
          want = pending_px.pop_front();
          check_field("out_blue", want.blue, out_ch.out_blue);
          check_field("out_green", want.green, out_ch.out_green);
          check_field("out_red", want.red, out_ch.out_red);
          check_field("pad_after", 8'(want.pad), 8'(out_ch.pad_after));
          check_field("row_end", 8'(want.row_end), 8'(out_ch.row_end));
          check_field("refused", 8'(want.refused), 8'(out_ch.refused));
          check_field("last", 8'(want.last_copy), 8'(out_ch.last));
        end
        stall_left = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) break;
    end
    $display("nearest_neighbor_upscaler regression: fail");
    $finish;
  end

  // Right after reset both registers read as one, so every pixel is its own
  // row of three bytes and needs one byte of padding. A tick has nothing to
  // replay and must vanish.
  task automatic test_power_on_defaults();
    send_item(KIND_PIXEL, 24'h000000);
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_tick();
  endtask

  // Zero in either register behaves as one, a width beyond the line store
  // behaves as the full store, and narrowing the width below the current
  // column ends the row on the next pixel. The row then owes one replay, so a
  // pixel is refused until the two ticks have replayed it.
  task automatic test_register_clamps();
    write_reg(REG_SCALE, 0);
    write_reg(REG_WIDTH, 0);
    send_item(KIND_PIXEL, 24'hA5_5A_C3);
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_SCALE, 2);
    send_item(KIND_PIXEL, 24'h12_34_56);
    send_item(KIND_PIXEL, 24'hED_CB_A9);
    write_reg(REG_WIDTH, 2);
    send_item(KIND_PIXEL, 24'h80_01_7F);
    send_item(KIND_PIXEL, 24'hFF_00_FF);
    send_tick();
    send_tick();
  endtask

  // A scale just above the limit acts as sixteen copies and fifteen owed rows.
  // Part way through the replay the scale is lowered: the owed rows stay, but
  // the remaining ticks come out at the new scale.
  task automatic test_max_scale_replay();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_SCALE, 17);
    send_item(KIND_PIXEL, 24'h3C_C3_99);
    send_item(KIND_PIXEL, 24'h66_66_66);
    repeat (5) send_tick();
    write_reg(REG_SCALE, 3);
    while (rows_owed > 0) send_tick();
  endtask

  // The receiver holds off for a long stretch while pixels arrive back to
  // back, so the block must fill up and stall its input. Half way through the
  // replay the sender stops until every expected result has come out.
  task automatic test_backpressure();
    write_reg(REG_SCALE, 4);
    write_reg(REG_WIDTH, 3);
    tx_steady = 1'b1;
    hold_req = 120;
    repeat (3) send_item(KIND_PIXEL, any_pixel());
    send_item(KIND_PIXEL, any_pixel());
    repeat (4) send_tick();
    wait_drain();
    send_item(KIND_PIXEL, any_pixel());
    while (rows_owed > 0) send_tick();
    tx_steady = 1'b0;
  endtask

  // Random frames: pick a setting, feed one source row, then replay it with
  // ticks. Most frames are well formed; some carry stray ticks, pixels that
  // land during replay, or a row cut short so that the next setting meets a
  // half-written row. Large scales come only with narrow rows to keep the
  // run short. Registers never change while rows are owed, so a replay never
  // reads a column that was not written.
  task automatic test_random_frames();
    int start_count;
    int unsigned s;
    int unsigned w;
    bit cut_row;
    start_count = items_counted;
    while (items_counted - start_count < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: s = 0;
        1: s = $urandom_range(5, 31);
        default: s = $urandom_range(1, 4);
      endcase
      if (s > 4) begin
        w = $urandom_range(0, 2);
      end else begin
        case ($urandom_range(0, 7))
          0: w = 0;
          1: w = $urandom_range(7, 20);
          default: w = $urandom_range(1, 6);
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SCALE, s);
        write_reg(REG_WIDTH, w);
      end else begin
        write_reg(REG_WIDTH, w);
        write_reg(REG_SCALE, s);
      end
      cut_row = ($urandom_range(0, 7) == 0);
      row_closed = 1'b0;
      while (!row_closed) begin
        if (cut_row && $urandom_range(0, 2) == 0) break;
        if ($urandom_range(0, 9) == 0) send_tick();
        else send_item(KIND_PIXEL, any_pixel());
      end
      while (rows_owed > 0) begin
        if ($urandom_range(0, 11) == 0) send_item(KIND_PIXEL, any_pixel());
        else send_tick();
        if ($urandom_range(0, 39) == 0) wait_drain();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_PIXEL;
    in_ch.blue   = 8'd0;
    in_ch.green  = 8'd0;
    in_ch.red    = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SCALE;
    cfg_ch.data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_defaults();
    test_register_clamps();
    test_max_scale_replay();
    test_backpressure();
    test_random_frames();

    // Let any trailing tick clear so a stray result would still be caught.
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("nearest_neighbor_upscaler regression: pass");
    end else begin
      $display("nearest_neighbor_upscaler regression: fail");
    end
    $finish;
  end

endmodule
